// ----- rtl/tbvc_pkg.sv -----
// Package with the shared constants, codes and command types of the velocity controller.
package tbvc_pkg;

  localparam int unsigned GAIN_W = 24;
  localparam int unsigned DRIVE_W = 17;
  localparam int unsigned SPEED_W = 12;
  localparam int unsigned RPM_W = 9;
  localparam int unsigned MV_W = 15;
  localparam int unsigned ERR_W = 15;
  localparam int unsigned PROD_W = 39;

  localparam logic [1:0] MODE_TICK = 2'd0;
  localparam logic [1:0] MODE_TARGET = 2'd1;
  localparam logic [1:0] MODE_REVERSE = 2'd2;

  localparam logic [1:0] SIGN_ZERO = 2'b00;
  localparam logic [1:0] SIGN_POS = 2'b01;
  localparam logic [1:0] SIGN_NEG = 2'b11;

  localparam logic [DRIVE_W-1:0] FULL_DRIVE = 17'd65536;
  localparam logic [SPEED_W-1:0] TOP_SPEED = 12'd3600;
  localparam logic [13:0] FULL_MV = 14'd12000;
  localparam logic signed [MV_W-1:0] NEG_FULL_MV = -15'sd12000;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd256;

  // Target to Q1.16 drive is t * 4096 / 225, taken by reciprocal and corrected once.
  localparam logic [16:0] GUESS_RECIP = 17'd74565;
  localparam logic [7:0] GUESS_DIVISOR = 8'd225;

  typedef struct packed {
    logic accept;
    logic set_target;
    logic toggle_rev;
    logic mul;
    logic sum;
    logic tgt_guess;
    logic tgt_fix;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic reverse_active;
  } dp_status_t;

endpackage

// ----- rtl/take_back_half_velocity_control.sv -----
// Top level of the take back half flywheel velocity controller.
// A control tick forms the error as the beat is taken, then passes the multiply state for the
// gain multiply, the sum state for the integrate, clamp and crossing update, and the output
// state for the millivolt scaling into the result register. A tick while reverse spin is
// active goes straight to the output state. A set target beat passes the guess state for the
// reciprocal multiply and the fix state for its correction or the given estimate. A toggle of
// reverse spin, or an unused mode, gives no result. Input stalls while a beat is in work, and
// a tick also waits in the output state while a previous result is still stalled at the output.
module take_back_half_velocity_control (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tbvc_pkg::GAIN_W-1:0]       cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        mode_i,
  input  logic signed [tbvc_pkg::RPM_W-1:0] measured_rpm_i,
  input  logic [tbvc_pkg::SPEED_W-1:0]      target_speed_i,
  input  logic                              estimate_given_i,
  input  logic [tbvc_pkg::DRIVE_W-1:0]      drive_estimate_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [tbvc_pkg::MV_W-1:0]  motor_millivolts_o,
  output logic [tbvc_pkg::DRIVE_W-1:0]      drive_level_o
);

  tbvc_pkg::dp_cmd_t cmd;
  tbvc_pkg::dp_status_t status;

  tbvc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tbvc_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .measured_rpm_i     (measured_rpm_i),
    .target_speed_i     (target_speed_i),
    .estimate_given_i   (estimate_given_i),
    .drive_estimate_i   (drive_estimate_i),
    .motor_millivolts_o (motor_millivolts_o),
    .drive_level_o      (drive_level_o)
  );

endmodule

// ----- rtl/tbvc_dp.sv -----
// Datapath of the velocity controller: controller state, arithmetic and the result register.
module tbvc_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  tbvc_pkg::dp_cmd_t                     cmd_i,
  output tbvc_pkg::dp_status_t                  status_o,
  input  logic                                  cfg_we_i,
  input  logic [tbvc_pkg::GAIN_W-1:0]           cfg_wdata_i,
  input  logic signed [tbvc_pkg::RPM_W-1:0]     measured_rpm_i,
  input  logic [tbvc_pkg::SPEED_W-1:0]          target_speed_i,
  input  logic                                  estimate_given_i,
  input  logic [tbvc_pkg::DRIVE_W-1:0]          drive_estimate_i,
  output logic signed [tbvc_pkg::MV_W-1:0]      motor_millivolts_o,
  output logic [tbvc_pkg::DRIVE_W-1:0]          drive_level_o
);

  logic [tbvc_pkg::GAIN_W-1:0] gain_q;
  logic [tbvc_pkg::SPEED_W-1:0] target_q;
  logic [1:0] sign_q;
  logic [tbvc_pkg::DRIVE_W-1:0] drive_q, crossing_q, guess_q;
  logic await_q, reverse_q;

  logic signed [tbvc_pkg::ERR_W-1:0] err_q;
  logic signed [tbvc_pkg::PROD_W-1:0] prod_q;
  logic est_given_q;
  logic [tbvc_pkg::DRIVE_W-1:0] est_sat_q, q0_q;
  logic signed [tbvc_pkg::MV_W-1:0] mv_q;
  logic [tbvc_pkg::DRIVE_W-1:0] level_q;

  logic [tbvc_pkg::SPEED_W-1:0] target_sat, target_sel;
  logic signed [tbvc_pkg::ERR_W-1:0] rpm_ext, rpm_scaled, err_d;
  logic [tbvc_pkg::DRIVE_W-1:0] est_sat;
  logic signed [tbvc_pkg::PROD_W-1:0] prod_d, rounded;
  logic signed [30:0] inc;
  logic signed [31:0] sum_w;
  logic [tbvc_pkg::DRIVE_W-1:0] clamped, mean, drive_d;
  logic [17:0] mean_sum;
  logic [1:0] err_sign;
  logic crossed;
  logic [28:0] recip_prod;
  logic [24:0] q0_times, remainder;
  logic [tbvc_pkg::DRIVE_W-1:0] guess_calc;
  logic [29:0] mv_prod;

  assign status_o.reverse_active = reverse_q;

  assign target_sat = (target_speed_i > tbvc_pkg::TOP_SPEED) ? tbvc_pkg::TOP_SPEED
                                                             : target_speed_i;
  assign target_sel = cmd_i.set_target ? target_sat : target_q;
  assign rpm_ext = {{(tbvc_pkg::ERR_W - tbvc_pkg::RPM_W){measured_rpm_i[tbvc_pkg::RPM_W-1]}},
                    measured_rpm_i};
  assign rpm_scaled = (rpm_ext <<< 4) + (rpm_ext <<< 1);
  assign err_d = $signed({3'b000, target_sel}) - rpm_scaled;
  assign est_sat = (drive_estimate_i > tbvc_pkg::FULL_DRIVE) ? tbvc_pkg::FULL_DRIVE
                                                             : drive_estimate_i;

  assign prod_d = $signed({{24{err_q[tbvc_pkg::ERR_W-1]}}, err_q})
                * $signed({15'b0, gain_q});

  assign rounded = prod_q + 39'sd128;
  assign inc = rounded[38:8];
  assign sum_w = $signed({15'b0, drive_q}) + $signed({inc[30], inc});

  always_comb begin
    if (sum_w[31]) begin
      clamped = '0;
    end else if (sum_w > $signed({15'b0, tbvc_pkg::FULL_DRIVE})) begin
      clamped = tbvc_pkg::FULL_DRIVE;
    end else begin
      clamped = sum_w[16:0];
    end
  end

  assign err_sign = (err_q == '0) ? tbvc_pkg::SIGN_ZERO
                  : (err_q[tbvc_pkg::ERR_W-1] ? tbvc_pkg::SIGN_NEG : tbvc_pkg::SIGN_POS);
  assign crossed = (err_sign != sign_q);
  assign mean_sum = {1'b0, clamped} + {1'b0, crossing_q};
  assign mean = mean_sum[17:1];

  always_comb begin
    drive_d = clamped;
    if (crossed) begin
      drive_d = await_q ? guess_q : mean;
    end
  end

  assign recip_prod = {12'b0, target_q} * {12'b0, tbvc_pkg::GUESS_RECIP};
  assign q0_times = {8'b0, q0_q} * {17'b0, tbvc_pkg::GUESS_DIVISOR};
  assign remainder = {1'b0, target_q, 12'b0} - q0_times;
  assign guess_calc = (remainder >= {17'b0, tbvc_pkg::GUESS_DIVISOR}) ? q0_q + 17'd1 : q0_q;

  assign mv_prod = ({13'b0, drive_q} * {16'b0, tbvc_pkg::FULL_MV}) + 30'd32768;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= tbvc_pkg::GAIN_RESET;
      target_q <= '0;
      sign_q <= tbvc_pkg::SIGN_ZERO;
      drive_q <= '0;
      crossing_q <= '0;
      guess_q <= '0;
      await_q <= 1'b0;
      reverse_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        gain_q <= cfg_wdata_i;
      end
      if (cmd_i.set_target) begin
        target_q <= target_sat;
      end
      if (cmd_i.toggle_rev) begin
        reverse_q <= ~reverse_q;
      end
      if (cmd_i.tgt_guess) begin
        sign_q <= err_sign;
        await_q <= 1'b1;
        crossing_q <= '0;
      end
      if (cmd_i.tgt_fix) begin
        guess_q <= est_given_q ? est_sat_q : guess_calc;
      end
      if (cmd_i.sum) begin
        drive_q <= drive_d;
        sign_q <= err_sign;
        if (crossed) begin
          crossing_q <= drive_d;
          if (await_q) begin
            await_q <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      err_q <= err_d;
      est_given_q <= estimate_given_i;
      est_sat_q <= est_sat;
    end
    if (cmd_i.mul) begin
      prod_q <= prod_d;
    end
    if (cmd_i.tgt_guess) begin
      q0_q <= recip_prod[28:12];
    end
    if (cmd_i.load_out) begin
      mv_q <= reverse_q ? tbvc_pkg::NEG_FULL_MV
                        : $signed({1'b0, mv_prod[29:16]});
      level_q <= drive_q;
    end
  end

  assign motor_millivolts_o = mv_q;
  assign drive_level_o = level_q;

`ifndef NO_ASSERTIONS
  a_drive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drive_q <= tbvc_pkg::FULL_DRIVE)
    else $error("drive level above full drive");
  a_guess_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.tgt_fix |=> guess_q <= tbvc_pkg::FULL_DRIVE)
    else $error("first crossing guess above full drive");
  a_sign_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sign_q == tbvc_pkg::SIGN_ZERO) || (sign_q == tbvc_pkg::SIGN_POS) ||
    (sign_q == tbvc_pkg::SIGN_NEG))
    else $error("invalid error sign code");
`endif

endmodule

// ----- rtl/tbvc_ctrl.sv -----
// Controller state machine that sequences ticks, target updates and result beats.
module tbvc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           mode_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  tbvc_pkg::dp_status_t status_i,
  output tbvc_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SUM,
    S_GUESS,
    S_FIX,
    S_OUT
  } state_e;

  state_e state_q;
  logic out_valid_q;
  logic accept, slot_free;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept = in_valid_i && (state_q == S_IDLE);
  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o = '0;
    cmd_o.accept = accept;
    cmd_o.set_target = accept && (mode_i == tbvc_pkg::MODE_TARGET);
    cmd_o.toggle_rev = accept && (mode_i == tbvc_pkg::MODE_REVERSE);
    cmd_o.mul = (state_q == S_MUL);
    cmd_o.sum = (state_q == S_SUM);
    cmd_o.tgt_guess = (state_q == S_GUESS);
    cmd_o.tgt_fix = (state_q == S_FIX);
    cmd_o.load_out = (state_q == S_OUT) && slot_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            unique case (mode_i)
              tbvc_pkg::MODE_TICK: begin
                state_q <= status_i.reverse_active ? S_OUT : S_MUL;
              end
              tbvc_pkg::MODE_TARGET: begin
                state_q <= S_GUESS;
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end
        end
        S_MUL: begin
          state_q <= S_SUM;
        end
        S_SUM: begin
          state_q <= S_OUT;
        end
        S_GUESS: begin
          state_q <= S_FIX;
        end
        S_FIX: begin
          state_q <= S_IDLE;
        end
        S_OUT: begin
          if (slot_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || !out_stall_i))
    else $error("result loaded over a pending beat");
  a_hold_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q)
    else $error("stalled result beat dropped");
  a_rise_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_OUT)
    else $error("result beat raised outside the output state");
`endif

endmodule
